// File: design/tpcd_pkg.sv
// shared constants and stage payload types for the touch packet coordinate decoder
package tpcd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DATA_W    = 7;
  localparam int unsigned RAW_W     = 2 * DATA_W;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned QY_W      = POS_W - 1;
  localparam int unsigned RECIP_W   = 24;
  localparam int unsigned PROD_W    = RAW_W + RECIP_W;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h80;

  localparam int unsigned X_MUL       = 799;
  localparam int unsigned X_DIV       = 4095;
  localparam int unsigned Y_MUL       = 479;
  localparam int unsigned Y_PRESS_OFF = 125;
  localparam int unsigned Y_PRESS_DIV = 3970;
  localparam int unsigned Y_REL_OFF   = 150;
  localparam int unsigned Y_REL_DIV   = 3945;

  // floor(n * mul / div) == floor(n * ceil(2^s * mul / div) / 2^s) holds for
  // n < 2^14 and div < 2^12 once s >= 26
  localparam int unsigned RECIP_SHIFT = 26;

  localparam logic [RECIP_W-1:0] X_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) * X_MUL + X_DIV - 1) / X_DIV);
  localparam logic [RECIP_W-1:0] Y_PRESS_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) * Y_MUL + Y_PRESS_DIV - 1) / Y_PRESS_DIV);
  localparam logic [RECIP_W-1:0] Y_REL_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) * Y_MUL + Y_REL_DIV - 1) / Y_REL_DIV);

  // assembled packet: raw x and the offset y split into sign and magnitude
  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] mag_y;
    logic             neg_y;
    logic             release_cal;
  } asm_item_t;

  // scaled magnitudes, y sign still apart
  typedef struct packed {
    logic [POS_W-1:0] q_x;
    logic [QY_W-1:0]  q_y;
    logic             neg_y;
  } scaled_item_t;

endpackage

// File: design/tpcd_pkt_asm.sv
// packet framing: sync hunt, data byte capture and raw value assembly
module tpcd_pkt_asm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tpcd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                           in_release,
  output logic                           item_valid,
  input  logic                           item_ready,
  output tpcd_pkg::asm_item_t            item
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_X_LO,
    PH_X_HI,
    PH_Y_LO,
    PH_Y_HI
  } phase_t;

  phase_t                          phase;
  logic [tpcd_pkg::DATA_W-1:0]     x_lo;
  logic [tpcd_pkg::DATA_W-1:0]     x_hi;
  logic [tpcd_pkg::DATA_W-1:0]     y_lo;

  logic                            take;
  logic [tpcd_pkg::DATA_W-1:0]     data;
  logic [tpcd_pkg::RAW_W-1:0]      raw_y;
  logic [tpcd_pkg::RAW_W:0]        diff_y;
  logic [tpcd_pkg::RAW_W:0]        neg_diff_y;

  assign in_ready = !item_valid || item_ready;
  assign take     = in_valid && in_ready;
  assign data     = in_byte[tpcd_pkg::DATA_W-1:0];   // top bit dropped

  always_comb begin
    raw_y      = {data, y_lo};
    diff_y     = {1'b0, raw_y} - (in_release ? (tpcd_pkg::RAW_W+1)'(tpcd_pkg::Y_REL_OFF)
                                              : (tpcd_pkg::RAW_W+1)'(tpcd_pkg::Y_PRESS_OFF));
    neg_diff_y = -diff_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      item_valid <= 1'b0;
    end else begin
      // drained item is cleared unless a new packet end refills it
      if (item_valid && item_ready && !(take && phase == PH_Y_HI)) begin
        item_valid <= 1'b0;
      end
      if (take) begin
        unique case (phase)
          PH_X_LO: begin
            x_lo  <= data;
            phase <= PH_X_HI;
          end
          PH_X_HI: begin
            x_hi  <= data;
            phase <= PH_Y_LO;
          end
          PH_Y_LO: begin
            y_lo  <= data;
            phase <= PH_Y_HI;
          end
          PH_Y_HI: begin
            item_valid       <= 1'b1;
            item.raw_x       <= {x_hi, x_lo};
            item.neg_y       <= diff_y[tpcd_pkg::RAW_W];
            item.mag_y       <= diff_y[tpcd_pkg::RAW_W] ? neg_diff_y[tpcd_pkg::RAW_W-1:0]
                                                        : diff_y[tpcd_pkg::RAW_W-1:0];
            item.release_cal <= in_release;
            phase            <= PH_IDLE;
          end
          default: begin
            // idle and unused codes hunt for sync
            phase <= (in_byte == tpcd_pkg::SYNC_BYTE) ? PH_X_LO : PH_IDLE;
          end
        endcase
      end
    end
  end

  // the last data byte of a packet always produces an item
  a_last_byte_emits: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_Y_HI |=> item_valid)
    else $error("packet end did not produce an item");

  // no item appears without a last data byte being taken
  a_item_from_packet: assert property (@(posedge clk) disable iff (rst)
    $rose(item_valid) |-> $past(take) && $past(phase) == PH_Y_HI)
    else $error("item appeared outside a packet end");

endmodule

// File: design/tpcd_scale.sv
// constant-reciprocal scaling of raw x and offset y magnitude
module tpcd_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tpcd_pkg::asm_item_t    in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tpcd_pkg::scaled_item_t out_item
);

  logic [tpcd_pkg::PROD_W-1:0]  prod_x;
  logic [tpcd_pkg::PROD_W-1:0]  prod_y;
  logic [tpcd_pkg::RECIP_W-1:0] recip_y;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    recip_y = in_item.release_cal ? tpcd_pkg::Y_REL_RECIP : tpcd_pkg::Y_PRESS_RECIP;
    prod_x  = tpcd_pkg::PROD_W'(in_item.raw_x) * tpcd_pkg::PROD_W'(tpcd_pkg::X_RECIP);
    prod_y  = tpcd_pkg::PROD_W'(in_item.mag_y) * tpcd_pkg::PROD_W'(recip_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item.q_x   <= prod_x[tpcd_pkg::RECIP_SHIFT +: tpcd_pkg::POS_W];
      out_item.q_y   <= prod_y[tpcd_pkg::RECIP_SHIFT +: tpcd_pkg::QY_W];
      out_item.neg_y <= in_item.neg_y;
    end
  end

endmodule

// File: design/tpcd_out.sv
// sign restore of y and the result register toward the output stream
module tpcd_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tpcd_pkg::scaled_item_t       in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tpcd_pkg::POS_W-1:0]   x_pos,
  output logic signed [tpcd_pkg::POS_W-1:0] y_pos
);

  logic [tpcd_pkg::POS_W-1:0] y_mag;

  assign in_ready = !out_valid || out_ready;
  assign y_mag    = {1'b0, in_item.q_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_pos <= in_item.q_x;
      y_pos <= in_item.neg_y ? -y_mag : y_mag;
    end
  end

  // scaled x never exceeds full scale of 3196
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> x_pos <= 12'd3196)
    else $error("x_pos beyond full scale");

  // y stays within the calibrated span
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> y_pos >= -12'sd18 && y_pos <= 12'sd1971)
    else $error("y_pos beyond calibrated span");

endmodule

// File: design/touch_packet_coordinate_decoder_core.sv
// top level of the touch packet coordinate decoder
//
//  channel  | direction | tdata (low bit up)           | tuser
//  ---------+-----------+------------------------------+------------------
//  s_axis   | in        | rx_byte[7:0]                 | release_cal
//  m_axis   | out       | x_pos[11:0], y_pos[23:12]    | -
//
// one byte transaction is taken per cycle while s_axis_tready is high; a packet is a sync byte 0x80
// followed by four data bytes, and only the last one yields a result
// the result of a packet passes from its last byte through the assembly register,
// the reciprocal multiply register and the sign restore / result register
// rst clears the phase to sync hunt and all stage valid flags
// m_axis_tready low holds each stage that holds an item; s_axis_tready drops only once the
// assembly register holds a packet that cannot move on
module touch_packet_coordinate_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic        s_axis_tuser,   // release_cal
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // x_pos[11:0], y_pos[23:12]
);

  // assembly stage to scaling stage
  logic                   asm_valid;
  logic                   asm_ready;
  tpcd_pkg::asm_item_t    asm_item;

  // scaling stage to result stage
  logic                   scl_valid;
  logic                   scl_ready;
  tpcd_pkg::scaled_item_t scl_item;

  logic [tpcd_pkg::POS_W-1:0]        x_pos;
  logic signed [tpcd_pkg::POS_W-1:0] y_pos;

  // sync hunt and byte capture, raw values joined and y offset applied
  tpcd_pkt_asm u_asm (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_release (s_axis_tuser),
    .item_valid (asm_valid),
    .item_ready (asm_ready),
    .item       (asm_item)
  );

  // divisions by 4095, 3970 and 3945 done as multiply by reciprocal
  tpcd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (asm_valid),
    .in_ready  (asm_ready),
    .in_item   (asm_item),
    .out_valid (scl_valid),
    .out_ready (scl_ready),
    .out_item  (scl_item)
  );

  // y sign restored, truncation toward zero kept by scaling the magnitude
  tpcd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_item   (scl_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .x_pos     (x_pos),
    .y_pos     (y_pos)
  );

  assign m_axis_tdata = {y_pos, x_pos};

endmodule
